// ----- design/spq_pkg.sv -----
package spq_pkg;

   localparam int LEVELS_DEF      = 4;
   localparam int RING_DEPTH_DEF  = 256;
   localparam int HANDLE_BITS_DEF = 16;

   localparam int HANDLE_FIELD_W = 16;
   localparam int LEVEL_FIELD_W  = 2;
   localparam int STATUS_W       = 2;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // Decision for one beat, from the pointer logic to the slot memory and result stage
   typedef struct packed {
      logic                     wr_en;
      logic                     rd_en;
      logic [STATUS_W-1:0]      status;
      logic [LEVEL_FIELD_W-1:0] level;
   } ring_op_type;

endpackage

// ----- design/strict_priority_ring_queue.sv -----
// Strict-priority task queue: one ring buffer of task handles per priority level.
// Request channel (req_valid/req_ready): req_cmd selects enqueue or dequeue,
//   req_level picks the ring for an enqueue, req_task_handle is the handle stored.
// Response channel (rsp_valid/rsp_ready): exactly one beat per request beat, in order.
//   rsp_status: stored, rejected full, delivered, or all rings empty.
//   rsp_out_handle/rsp_out_level carry the delivered handle and its level, else zero.
// A ring holds RING_DEPTH-1 handles; an enqueue to a full ring or to a level with
//   no ring is rejected and changes nothing. Dequeue serves level 0 first.
// The response is registered and valid in the cycle after the request beat is taken.
// Throughput: one request per cycle while responses are drained; the pointer
//   compare, the priority pick and one port each of the slot memory all act in the same cycle.
// The single response register takes a new beat in the same cycle the old one
//   leaves, so req_ready drops only while a response is stalled by rsp_ready.
// Synchronous reset empties every ring at once (head and tail pointers cleared);
//   slot memory contents are not cleared and are never read before written.
module strict_priority_ring_queue
   import spq_pkg::*;
#(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int RING_DEPTH  = RING_DEPTH_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [LEVEL_FIELD_W-1:0]  req_level,
   input  logic [HANDLE_FIELD_W-1:0] req_task_handle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [HANDLE_FIELD_W-1:0] rsp_out_handle,
   output logic [LEVEL_FIELD_W-1:0]  rsp_out_level
);

   localparam int PTR_W     = $clog2(RING_DEPTH);
   localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ADDR_W    = LVL_IDX_W + PTR_W;
   localparam int MEM_DEPTH = LEVELS * RING_DEPTH;
   localparam int EXT_W     = HANDLE_BITS + HANDLE_FIELD_W;

   logic                     fire;
   ring_op_type              op;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [EXT_W-1:0]         in_ext;
   logic [EXT_W-1:0]         out_ext;
   logic [HANDLE_BITS-1:0]   rd_data;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [STATUS_W-1:0]      status_ff;
   logic [LEVEL_FIELD_W-1:0] level_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   spq_ring_ctrl #(
      .LEVELS     (LEVELS),
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .cmd     (req_cmd),
      .level   (req_level),
      .op      (op),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr)
   );

   assign in_ext = {{HANDLE_BITS{1'b0}}, req_task_handle};

   spq_slot_ram #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (HANDLE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (op.wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_ext[HANDLE_BITS-1:0]),
      .rd_en   (op.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Advance on a new beat, drop once taken, otherwise hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= op.status;
         level_ff  <= op.level;
      end
   end

   assign out_ext = {{HANDLE_FIELD_W{1'b0}}, rd_data};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_level  = level_ff;
   assign rsp_out_handle = (status_ff == ST_DELIVERED) ? out_ext[HANDLE_FIELD_W-1:0] : '0;

endmodule

// ----- design/spq_slot_ram.sv -----
module spq_slot_ram
   import spq_pkg::*;
#(
   parameter int DEPTH  = LEVELS_DEF * RING_DEPTH_DEF,
   parameter int ADDR_W = $clog2(LEVELS_DEF * RING_DEPTH_DEF),
   parameter int DATA_W = HANDLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/spq_ring_ctrl.sv -----
module spq_ring_ctrl
   import spq_pkg::*;
#(
   parameter int LEVELS     = LEVELS_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   localparam int PTR_W     = $clog2(RING_DEPTH),
   localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1,
   localparam int ADDR_W    = LVL_IDX_W + PTR_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic                     cmd,
   input  logic [LEVEL_FIELD_W-1:0] level,
   output ring_op_type              op,
   output logic [ADDR_W-1:0]        wr_addr,
   output logic [ADDR_W-1:0]        rd_addr
);

   logic [PTR_W-1:0] head_ff [LEVELS];
   logic [PTR_W-1:0] head_in [LEVELS];
   logic [PTR_W-1:0] tail_ff [LEVELS];
   logic [PTR_W-1:0] tail_in [LEVELS];

   logic [LEVELS-1:0]    full;
   logic [LEVELS-1:0]    nonempty;
   logic                 lvl_hit;
   logic [LVL_IDX_W-1:0] enq_idx;
   logic                 enq_ok;
   logic [LVL_IDX_W-1:0] pick_idx;
   logic                 pick_any;
   logic                 do_enq;
   logic                 do_deq;

   // Full means the tail sits one slot behind the head
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         full[l]     = (PTR_W'(tail_ff[l] + 1'b1) == head_ff[l]);
         nonempty[l] = (head_ff[l] != tail_ff[l]);
      end
   end

   assign lvl_hit = (32'(level) < LEVELS);
   assign enq_idx = lvl_hit ? LVL_IDX_W'(level) : '0;
   assign enq_ok  = lvl_hit && !full[enq_idx];

   // Lowest-numbered non-empty level wins
   always_comb begin
      pick_idx = '0;
      pick_any = 1'b0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (nonempty[l]) begin
            pick_idx = LVL_IDX_W'(l);
            pick_any = 1'b1;
         end
      end
   end

   assign do_enq = fire && (cmd == CMD_ENQ) && enq_ok;
   assign do_deq = fire && (cmd == CMD_DEQ) && pick_any;

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         tail_in[l] = tail_ff[l];
         head_in[l] = head_ff[l];
         if (do_enq && (enq_idx == LVL_IDX_W'(l))) begin
            tail_in[l] = PTR_W'(tail_ff[l] + 1'b1);
         end
         if (do_deq && (pick_idx == LVL_IDX_W'(l))) begin
            head_in[l] = PTR_W'(head_ff[l] + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
         end
      end else begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= head_in[l];
            tail_ff[l] <= tail_in[l];
         end
      end
   end

   assign wr_addr = {enq_idx, tail_ff[enq_idx]};
   assign rd_addr = {pick_idx, head_ff[pick_idx]};

   always_comb begin
      op.wr_en = do_enq;
      op.rd_en = do_deq;
      if (cmd == CMD_ENQ) begin
         op.status = enq_ok ? ST_STORED : ST_FULL;
         op.level  = '0;
      end else begin
         op.status = pick_any ? ST_DELIVERED : ST_EMPTY;
         op.level  = pick_any ? LEVEL_FIELD_W'(pick_idx) : '0;
      end
   end

endmodule

// ----- design/spq_checker.sv -----
module spq_checker
   import spq_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_cmd,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic [HANDLE_FIELD_W-1:0] rsp_out_handle,
   input logic [LEVEL_FIELD_W-1:0]  rsp_out_level
);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_handle) && $stable(rsp_out_level))
      else $error("stalled response changed");

   // Every request beat yields a response beat in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request beat without response");

   // Only a delivery carries a handle or level
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DELIVERED) |-> (rsp_out_handle == '0)
         && (rsp_out_level == '0))
      else $error("nonzero fields without delivery");

   // Rings are empty right after reset
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_valid && req_ready && (req_cmd == CMD_DEQ)
         |=> rsp_status == ST_EMPTY)
      else $error("dequeue after reset not empty");

   // Ready is only withheld while a response is stalled
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side stalled without cause");

endmodule

bind strict_priority_ring_queue spq_checker u_spq_checker (.*);

// ----- test/tb_strict_priority_ring_queue.sv -----
module tb_strict_priority_ring_queue
   import spq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [HANDLE_FIELD_W-1:0] handle;
      logic [LEVEL_FIELD_W-1:0]  level;
   } ring_result_type;

   localparam logic [HANDLE_FIELD_W-1:0] HANDLE_KEEP =
      (HANDLE_BITS_DEF >= HANDLE_FIELD_W) ? '1 : HANDLE_FIELD_W'((1 << HANDLE_BITS_DEF) - 1);
   localparam int MAX_PRINTED = 50;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_cmd = CMD_ENQ;
   logic [LEVEL_FIELD_W-1:0]  req_level = '0;
   logic [HANDLE_FIELD_W-1:0] req_task_handle = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [HANDLE_FIELD_W-1:0] rsp_out_handle;
   logic [LEVEL_FIELD_W-1:0]  rsp_out_level;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatch_count = 0;

   // shadow copy of the rings
   int                        ring_head [LEVELS_DEF];
   int                        ring_tail [LEVELS_DEF];
   logic [HANDLE_FIELD_W-1:0] ring_slots [LEVELS_DEF][RING_DEPTH_DEF];

   ring_result_type pending_results[$];

   strict_priority_ring_queue u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_level       (req_level),
      .req_task_handle (req_task_handle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_out_level   (rsp_out_level)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int ring_fill(input int lvl);
      return (ring_tail[lvl] - ring_head[lvl] + RING_DEPTH_DEF) % RING_DEPTH_DEF;
   endfunction

   function automatic int total_fill();
      int sum;
      sum = 0;
      for (int i = 0; i < LEVELS_DEF; i++) sum += ring_fill(i);
      return sum;
   endfunction

   // Apply one queue operation to the shadow rings and return its result.
   function automatic ring_result_type predict_ring_op(input logic cmd,
                                                    input logic [LEVEL_FIELD_W-1:0] lvl,
                                                    input logic [HANDLE_FIELD_W-1:0] handle);
      ring_result_type r;
      int           nxt;
      bit           found;
      r = '0;
      found = 1'b0;
      if (cmd == CMD_ENQ) begin
         if (int'(lvl) >= LEVELS_DEF) begin
            r.status = ST_FULL;
         end else begin
            nxt = (ring_tail[lvl] + 1) % RING_DEPTH_DEF;
            if (nxt == ring_head[lvl]) begin
               r.status = ST_FULL;
            end else begin
               ring_slots[lvl][ring_tail[lvl]] = handle & HANDLE_KEEP;
               ring_tail[lvl] = nxt;
               r.status = ST_STORED;
            end
         end
      end else begin
         r.status = ST_EMPTY;
         for (int i = 0; i < LEVELS_DEF; i++) begin
            if (!found && ring_head[i] != ring_tail[i]) begin
               found = 1'b1;
               r.status = ST_DELIVERED;
               r.handle = ring_slots[i][ring_head[i]];
               r.level = LEVEL_FIELD_W'(i);
               ring_head[i] = (ring_head[i] + 1) % RING_DEPTH_DEF;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
   endtask

   task automatic send_beat(input logic cmd, input logic [LEVEL_FIELD_W-1:0] lvl,
                            input logic [HANDLE_FIELD_W-1:0] handle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_level       <= lvl;
      req_task_handle <= handle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_ring_op(cmd, lvl, handle));
   endtask

   // check each response beat against the oldest prediction, stall at random
   always @(posedge clock) begin
      ring_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response status", 0, 32'(rsp_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_out_handle !== want.handle)
               report_mismatch("out_handle", 32'(want.handle), 32'(rsp_out_handle));
            if (rsp_out_level !== want.level)
               report_mismatch("out_level", 32'(want.level), 32'(rsp_out_level));
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic test_directed();
      send_beat(CMD_DEQ, 2'd3, 16'hffff);           // nothing stored yet
      send_beat(CMD_ENQ, 2'd3, 16'hffff);
      send_beat(CMD_ENQ, 2'd2, 16'h0000);
      send_beat(CMD_ENQ, 2'd1, 16'haaaa);
      send_beat(CMD_ENQ, 2'd0, 16'h5555);
      send_beat(CMD_ENQ, 2'd0, 16'h0001);
      // level 0 drains first, oldest handle first
      repeat (5) send_beat(CMD_DEQ, 2'd0, 16'h1234);
      send_beat(CMD_DEQ, 2'd0, 16'h0000);
      send_beat(CMD_ENQ, 2'd3, 16'h8000);
      send_beat(CMD_ENQ, 2'd1, 16'h7fff);
      send_beat(CMD_DEQ, 2'd3, 16'hffff);
      send_beat(CMD_DEQ, 2'd1, 16'hffff);
      send_beat(CMD_DEQ, 2'd2, 16'hffff);
   endtask

   // fill one ring to its limit, hit the full case, then wrap the pointers
   task automatic test_ring_full();
      int lvl;
      lvl = $urandom_range(LEVELS_DEF - 1);
      while (ring_fill(lvl) < RING_DEPTH_DEF - 1)
         send_beat(CMD_ENQ, LEVEL_FIELD_W'(lvl), HANDLE_FIELD_W'($urandom));
      repeat (2) send_beat(CMD_ENQ, LEVEL_FIELD_W'(lvl), HANDLE_FIELD_W'($urandom));
      send_beat(CMD_ENQ, LEVEL_FIELD_W'((lvl + 1) % LEVELS_DEF), HANDLE_FIELD_W'($urandom));
      send_beat(CMD_DEQ, 2'd0, HANDLE_FIELD_W'($urandom));
      send_beat(CMD_DEQ, 2'd0, HANDLE_FIELD_W'($urandom));
      repeat (3) send_beat(CMD_ENQ, LEVEL_FIELD_W'(lvl), HANDLE_FIELD_W'($urandom));
      while (total_fill() != 0)
         send_beat(CMD_DEQ, LEVEL_FIELD_W'($urandom), HANDLE_FIELD_W'($urandom));
      send_beat(CMD_DEQ, 2'd0, 16'h0000);
      repeat (4) send_beat(CMD_ENQ, LEVEL_FIELD_W'(lvl), HANDLE_FIELD_W'($urandom));
      repeat (5) send_beat(CMD_DEQ, LEVEL_FIELD_W'($urandom), HANDLE_FIELD_W'($urandom));
   endtask

   // bursts with a random enqueue bias and a favored level, so rings swing
   // between empty and nearly full
   task automatic test_random_mix(input int n_items);
      int   sent;
      int   burst_len;
      int   enq_pct;
      int   focus;
      logic cmd;
      logic [LEVEL_FIELD_W-1:0] lvl;
      sent = 0;
      while (sent < n_items) begin
         burst_len = $urandom_range(300, 20);
         focus = $urandom_range(LEVELS_DEF - 1);
         case ($urandom_range(3))
            0: enq_pct = 15;
            1: enq_pct = 50;
            2: enq_pct = 85;
            default: enq_pct = 100;
         endcase
         while (burst_len > 0 && sent < n_items) begin
            cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            lvl = ($urandom_range(99) < 75) ? LEVEL_FIELD_W'(focus)
                                            : LEVEL_FIELD_W'($urandom);
            send_beat(cmd, lvl, HANDLE_FIELD_W'($urandom));
            burst_len--;
            sent++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < LEVELS_DEF; i++) begin
         ring_head[i] = 0;
         ring_tail[i] = 0;
      end
      send_idle_pct = 22;
      rsp_idle_pct = 80;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_ring_full();
      test_random_mix(150);
      send_idle_pct = 80;
      rsp_idle_pct = 22;
      test_random_mix(150);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_mix(150);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_strict_priority_ring_queue passed");
      end else begin
         $display("tb_strict_priority_ring_queue failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout waiting for response beats");
      $display("tb_strict_priority_ring_queue failed");
      $finish;
   end

endmodule
